FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ARA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator assertion failed");

// condition must never be seen outside reset
`define ARA_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("allocator forbidden condition seen");

`endif

FILE: rtl/core/ara_pkg.sv
// ----------------------------------------------------------------------------
// ara_pkg
// types and codes shared by the address range allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package ara_pkg;

    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_ALLOC   = 3'd1;
    localparam logic [2:0] REQ_FREE    = 3'd2;
    localparam logic [2:0] REQ_RESERVE = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_ALIGN     = 3'd2;
    localparam logic [2:0] ST_TABLEFULL = 3'd3;
    localparam logic [2:0] ST_NOSPACE   = 3'd4;
    localparam logic [2:0] ST_NOTFOUND  = 3'd5;

    localparam logic CFG_REGION_START = 1'b0;

    typedef struct packed {
        logic [63:0] start_addr;
        logic [63:0] end_addr;
        logic [63:0] usable_base;
        logic [15:0] guard_before;
        logic [15:0] guard_after;
        logic [2:0]  tag;
        logic [7:0]  order;
    } t_slot;

    typedef struct packed {
        logic [2:0]  op;
        logic        pass2;
        logic        prep1;
        logic        prep2;
        logic        place_high;
        logic [63:0] reserved;
        logic [63:0] amask;
        logic [63:0] align;
        logic [63:0] addr;
        logic [63:0] rend;
        logic [63:0] fs;
        logic [63:0] fe;
    } t_req;

    typedef struct packed {
        logic        hit;
        t_slot       slot;
        logic [63:0] len;
        logic [63:0] a;
        logic [63:0] b;
        logic        left_hit;
        logic [63:0] left_start;
        logic        right_hit;
        logic [63:0] right_end;
        logic        e1_v;
        logic        e2_v;
    } t_rec;

    typedef struct packed {
        logic        valid;
        logic        clr_all;
        logic        clr_l;
        logic        clr_r;
        logic        wa;
        logic        wb;
        logic        wm;
        logic [63:0] a_start;
        logic [63:0] a_end;
        logic [63:0] b_start;
        logic [63:0] b_end;
        logic        m_free;
        t_slot       m_slot;
    } t_cmt;

    function automatic t_slot mk_free(input logic [63:0] s, input logic [63:0] e);
        t_slot v;
        v              = '0;
        v.start_addr   = s;
        v.end_addr     = e;
        v.usable_base  = s;
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ara_cell.sv
// ----------------------------------------------------------------------------
// ara_cell
// one table slot: holds a range, precomputes its fit, updates the scan record
// ----------------------------------------------------------------------------
`default_nettype none

module ara_cell #(
    parameter int IDXW     = 6,
    parameter int CELL_IDX = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ara_pkg::t_req      i_req,
    input  ara_pkg::t_cmt      i_cmt,
    input  wire [IDXW-1:0]     i_km,
    input  wire [IDXW-1:0]     i_ka,
    input  wire [IDXW-1:0]     i_kb,
    input  wire [IDXW-1:0]     i_kl,
    input  wire [IDXW-1:0]     i_kr,
    input  wire                i_v,
    input  ara_pkg::t_rec      i_rec,
    input  wire [IDXW-1:0]     i_hit_idx,
    input  wire [IDXW-1:0]     i_l_idx,
    input  wire [IDXW-1:0]     i_r_idx,
    input  wire [IDXW-1:0]     i_e1_idx,
    input  wire [IDXW-1:0]     i_e2_idx,
    output logic               o_v,
    output ara_pkg::t_rec      o_rec,
    output logic [IDXW-1:0]    o_hit_idx,
    output logic [IDXW-1:0]    o_l_idx,
    output logic [IDXW-1:0]    o_r_idx,
    output logic [IDXW-1:0]    o_e1_idx,
    output logic [IDXW-1:0]    o_e2_idx,
    output logic               o_used
);

    localparam logic [IDXW-1:0] ME = IDXW'(CELL_IDX);

    logic          r_used;
    logic          r_free;
    ara_pkg::t_slot r_slot;
    logic [63:0]   r_len;
    logic [63:0]   r_a;
    logic [63:0]   r_b;
    logic          r_ovf1;
    logic          r_eles;
    logic          r_fit;

    logic          r_v;
    ara_pkg::t_rec r_rec;
    logic [IDXW-1:0] r_hit_idx, r_l_idx, r_r_idx, r_e1_idx, r_e2_idx;

    ara_pkg::t_rec n_rec;
    logic [IDXW-1:0] n_hit_idx, n_l_idx, n_r_idx, n_e1_idx, n_e2_idx;

    logic [64:0]   w_lo_sum;
    logic          w_lo_nz;
    logic [63:0]   w_a_lo;
    logic [63:0]   w_a_hi;
    logic [64:0]   w_b;
    logic          w_fit_hi;
    logic          w_fit_lo;
    logic          w_kill;
    logic          w_take;

    // fit precompute
    assign w_lo_sum = {1'b0, r_slot.start_addr & ~i_req.amask} + {1'b0, i_req.align};
    assign w_lo_nz  = |(r_slot.start_addr & i_req.amask);
    assign w_a_lo   = w_lo_nz ? w_lo_sum[63:0] : r_slot.start_addr;
    assign w_a_hi   = (r_slot.end_addr - i_req.reserved) & ~i_req.amask;
    assign w_b      = {1'b0, r_a} + {1'b0, i_req.reserved};
    assign w_fit_hi = r_a >= r_slot.start_addr;
    assign w_fit_lo = !r_ovf1 && !w_b[64] && (w_b[63:0] <= r_slot.end_addr);

    always_ff @(posedge i_clk) begin
        if (i_req.prep1) begin
            r_len  <= r_slot.end_addr - r_slot.start_addr;
            r_eles <= r_slot.end_addr < r_slot.start_addr;
            r_a    <= i_req.place_high ? w_a_hi : w_a_lo;
            r_ovf1 <= !i_req.place_high && w_lo_nz && w_lo_sum[64];
        end
        if (i_req.prep2) begin
            r_b   <= w_b[63:0];
            r_fit <= r_used && r_free && !r_eles && (r_len >= i_req.reserved) &&
                     (i_req.place_high ? w_fit_hi : w_fit_lo);
        end
    end

    // scan record update
    always_comb begin
        n_rec     = i_rec;
        n_hit_idx = i_hit_idx;
        n_l_idx   = i_l_idx;
        n_r_idx   = i_r_idx;
        n_e1_idx  = i_e1_idx;
        n_e2_idx  = i_e2_idx;
        w_take    = 1'b0;
        if (!r_used) begin
            if (!i_rec.e1_v) begin
                n_rec.e1_v = 1'b1;
                n_e1_idx   = ME;
            end else if (!i_rec.e2_v) begin
                n_rec.e2_v = 1'b1;
                n_e2_idx   = ME;
            end
        end
        case (i_req.op)
            ara_pkg::REQ_ALLOC: begin
                w_take = r_fit && (!i_rec.hit || (r_len < i_rec.len) ||
                         ((r_len == i_rec.len) &&
                          (r_slot.start_addr < i_rec.slot.start_addr)));
            end
            ara_pkg::REQ_FREE: begin
                if (!i_req.pass2) begin
                    w_take = !i_rec.hit && r_used && !r_free &&
                             (r_slot.usable_base == i_req.addr);
                end else begin
                    if (!i_rec.left_hit && r_used && r_free &&
                        (r_slot.end_addr == i_req.fs) && (r_slot.start_addr < i_req.fs)) begin
                        n_rec.left_hit   = 1'b1;
                        n_rec.left_start = r_slot.start_addr;
                        n_l_idx          = ME;
                    end
                    if (!i_rec.right_hit && r_used && r_free &&
                        (r_slot.start_addr == i_req.fe) && (r_slot.end_addr > i_req.fe)) begin
                        n_rec.right_hit = 1'b1;
                        n_rec.right_end = r_slot.end_addr;
                        n_r_idx         = ME;
                    end
                end
            end
            ara_pkg::REQ_RESERVE: begin
                w_take = !i_rec.hit && r_used && r_free &&
                         (r_slot.start_addr <= i_req.addr) && (r_slot.end_addr >= i_req.rend);
            end
            ara_pkg::REQ_QUERY: begin
                w_take = !i_rec.hit && r_used && !r_free &&
                         (r_slot.start_addr <= i_req.addr) && (i_req.addr < r_slot.end_addr);
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
        if (w_take) begin
            n_rec.hit  = 1'b1;
            n_rec.slot = r_slot;
            n_rec.len  = r_len;
            n_rec.a    = r_a;
            n_rec.b    = r_b;
            n_hit_idx  = ME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec     <= n_rec;
        r_hit_idx <= n_hit_idx;
        r_l_idx   <= n_l_idx;
        r_r_idx   <= n_r_idx;
        r_e1_idx  <= n_e1_idx;
        r_e2_idx  <= n_e2_idx;
    end

    // slot state
    assign w_kill = i_cmt.clr_all || (i_cmt.clr_l && (i_kl == ME)) ||
                    (i_cmt.clr_r && (i_kr == ME));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmt.valid) begin
            if (w_kill) begin
                r_used <= 1'b0;
                r_free <= 1'b0;
            end
            if ((i_cmt.wa && (i_ka == ME)) || (i_cmt.wb && (i_kb == ME))) begin
                r_used <= 1'b1;
                r_free <= 1'b1;
            end
            if (i_cmt.wm && (i_km == ME)) begin
                r_used <= 1'b1;
                r_free <= i_cmt.m_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmt.valid) begin
            if (i_cmt.wa && (i_ka == ME)) begin
                r_slot <= ara_pkg::mk_free(i_cmt.a_start, i_cmt.a_end);
            end
            if (i_cmt.wb && (i_kb == ME)) begin
                r_slot <= ara_pkg::mk_free(i_cmt.b_start, i_cmt.b_end);
            end
            if (i_cmt.wm && (i_km == ME)) begin
                r_slot <= i_cmt.m_slot;
            end
        end
    end

    assign o_v       = r_v;
    assign o_rec     = r_rec;
    assign o_hit_idx = r_hit_idx;
    assign o_l_idx   = r_l_idx;
    assign o_r_idx   = r_r_idx;
    assign o_e1_idx  = r_e1_idx;
    assign o_e2_idx  = r_e2_idx;
    assign o_used    = r_used;

endmodule

`default_nettype wire

FILE: rtl/core/address_range_allocator.sv
// ----------------------------------------------------------------------------
// address_range_allocator
// best fit range allocator with merging of free neighbors over a slot chain
// ----------------------------------------------------------------------------
// usage:
//   config port: write region_start (index 0) and region_end (index 1) while
//   idle, then send an init request to seed the window as one free range.
//   request channel (i_valid / o_ready) takes one transaction at a time;
//   o_ready is high only while no request is in progress.
//   result channel (o_valid / i_ready) returns one transaction per request
//   from an output register, so a stalled receiver does not block the finish
//   of the next request's processing, only its delivery.
//   argument errors and init skip the slot chain scan; alloc, reserve and
//   query scan the chain once, and free scans it a second time to find the
//   free neighbors once its first pass finds the range. the scan record
//   walks the slot chain one cell per cycle.
//   reset clears the config registers and marks every slot empty; the slot
//   contents themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module address_range_allocator #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int PAGE_BYTES      = 4096,
    parameter int MAX_BUDDY_ORDER = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_req_type,
    input  wire  [63:0] i_addr,
    input  wire  [63:0] i_req_size,
    input  wire  [63:0] i_alignment,
    input  wire  [15:0] i_guard_before,
    input  wire  [15:0] i_guard_after,
    input  wire         i_place_high,
    input  wire  [2:0]  i_alloc_tag,
    input  wire  [7:0]  i_order_hint,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_res_base,
    output logic [63:0] o_res_size,
    output logic [63:0] o_res_reserved_base,
    output logic [63:0] o_res_reserved_size,
    output logic [15:0] o_res_guard_before,
    output logic [15:0] o_res_guard_after,
    output logic [2:0]  o_res_tag,
    output logic [7:0]  o_res_order
);

    localparam int          IDXW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int          PLOG   = $clog2(PAGE_BYTES);
    localparam logic [63:0] PMASK  = 64'(PAGE_BYTES - 1);
    localparam logic [63:0] PBYTES = 64'(PAGE_BYTES);
    localparam logic [7:0]  MAXORD = 8'(MAX_BUDDY_ORDER);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHK1   = 9'b000000010,
        S_CHK2   = 9'b000000100,
        S_PREP1  = 9'b000001000,
        S_PREP2  = 9'b000010000,
        S_SCAN   = 9'b000100000,
        S_DEC    = 9'b001000000,
        S_COMMIT = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state      r_state;
    logic [63:0] r_rs, r_re;
    logic [2:0]  r_op;
    logic [63:0] r_addr, r_size, r_align, r_amask;
    logic [15:0] r_gb, r_ga;
    logic        r_ph;
    logic [2:0]  r_tag;
    logic [7:0]  r_order;
    logic        r_err;
    logic [2:0]  r_st;
    logic [63:0] r_usable, r_gbytes, r_reserved, r_rend;
    logic        r_szovf;
    logic        r_pass2;
    logic        r_kick;
    logic [63:0] r_fs, r_fe;
    logic [IDXW-1:0] r_n;
    ara_pkg::t_rec   r_fin;
    logic [IDXW-1:0] r_fin_hit, r_fin_l, r_fin_r, r_fin_e1, r_fin_e2;
    logic        r_pre, r_suf;
    logic [63:0] r_ubase, r_gbq;
    logic [63:0] r_res_base, r_res_size, r_res_rbase, r_res_rsize;
    logic [15:0] r_res_gb, r_res_ga;
    logic [2:0]  r_res_tag;
    logic [7:0]  r_res_order;

    logic        r_out_v;
    logic [2:0]  r_out_st;
    logic [63:0] r_out_base, r_out_size, r_out_rbase, r_out_rsize;
    logic [15:0] r_out_gb, r_out_ga;
    logic [2:0]  r_out_tag;
    logic [7:0]  r_out_order;

    ara_pkg::t_req w_req;
    ara_pkg::t_cmt w_cmt;
    logic [IDXW-1:0] w_km, w_ka, w_kb;

    logic [TABLE_ENTRIES:0]  w_v;
    ara_pkg::t_rec           w_rec    [0:TABLE_ENTRIES];
    logic [IDXW-1:0]         w_hit    [0:TABLE_ENTRIES];
    logic [IDXW-1:0]         w_li     [0:TABLE_ENTRIES];
    logic [IDXW-1:0]         w_ri     [0:TABLE_ENTRIES];
    logic [IDXW-1:0]         w_e1     [0:TABLE_ENTRIES];
    logic [IDXW-1:0]         w_e2     [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_used;

    logic        w_chk_err;
    logic [2:0]  w_chk_st;
    logic [64:0] w_usum;
    logic [64:0] w_rsum;
    logic [64:0] w_esum;
    logic [63:0] w_ca, w_cb;
    logic        w_is_alloc;

    // request checks
    assign w_usum = {1'b0, r_size} + {1'b0, PMASK};
    assign w_rsum = {1'b0, r_usable} + {1'b0, r_gbytes};
    assign w_esum = {1'b0, r_addr} + {1'b0, r_usable};

    always_comb begin
        w_chk_err = 1'b0;
        w_chk_st  = ara_pkg::ST_OK;
        case (r_op)
            ara_pkg::REQ_INIT: begin
                if (r_rs >= r_re) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_INVALID;
                end else if (|((r_rs | r_re) & PMASK)) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_ALIGN;
                end
            end
            ara_pkg::REQ_ALLOC: begin
                if (r_size == 64'd0) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_INVALID;
                end else if ((r_align == 64'd0) || (|(r_align & (r_align - 64'd1))) ||
                             (r_align < PBYTES)) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_ALIGN;
                end else if (r_order > MAXORD) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_INVALID;
                end
            end
            ara_pkg::REQ_RESERVE: begin
                if (r_size == 64'd0) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_INVALID;
                end else if (|(r_addr & PMASK)) begin
                    w_chk_err = 1'b1;
                    w_chk_st  = ara_pkg::ST_ALIGN;
                end
            end
            ara_pkg::REQ_FREE, ara_pkg::REQ_QUERY: begin
                w_chk_err = 1'b0;
            end
            default: begin
                w_chk_err = 1'b1;
                w_chk_st  = ara_pkg::ST_INVALID;
            end
        endcase
    end

    assign w_is_alloc = (r_op == ara_pkg::REQ_ALLOC);
    assign w_ca       = w_is_alloc ? r_fin.a : r_addr;
    assign w_cb       = w_is_alloc ? r_fin.b : r_rend;

    // broadcast to the cells
    always_comb begin
        w_req            = '0;
        w_req.op         = r_op;
        w_req.pass2      = r_pass2;
        w_req.prep1      = (r_state == S_PREP1);
        w_req.prep2      = (r_state == S_PREP2);
        w_req.place_high = r_ph;
        w_req.reserved   = r_reserved;
        w_req.amask      = r_amask;
        w_req.align      = r_align;
        w_req.addr       = r_addr;
        w_req.rend       = r_rend;
        w_req.fs         = r_fs;
        w_req.fe         = r_fe;
    end

    always_comb begin
        w_cmt = '0;
        w_km  = '0;
        w_ka  = r_fin_e1;
        w_kb  = r_pre ? r_fin_e2 : r_fin_e1;
        if ((r_state == S_COMMIT) && !r_err) begin
            case (r_op)
                ara_pkg::REQ_INIT: begin
                    w_cmt.valid   = 1'b1;
                    w_cmt.clr_all = 1'b1;
                    w_cmt.wm      = 1'b1;
                    w_cmt.m_free  = 1'b1;
                    w_cmt.m_slot  = ara_pkg::mk_free(r_rs, r_re);
                end
                ara_pkg::REQ_ALLOC, ara_pkg::REQ_RESERVE: begin
                    w_cmt.valid   = 1'b1;
                    w_cmt.wa      = r_pre;
                    w_cmt.a_start = r_fin.slot.start_addr;
                    w_cmt.a_end   = w_ca;
                    w_cmt.wb      = r_suf;
                    w_cmt.b_start = w_cb;
                    w_cmt.b_end   = r_fin.slot.end_addr;
                    w_cmt.wm      = 1'b1;
                    w_cmt.m_free  = 1'b0;
                    w_cmt.m_slot.start_addr   = w_ca;
                    w_cmt.m_slot.end_addr     = w_cb;
                    w_cmt.m_slot.usable_base  = r_ubase;
                    w_cmt.m_slot.guard_before = w_is_alloc ? r_gb : 16'd0;
                    w_cmt.m_slot.guard_after  = w_is_alloc ? r_ga : 16'd0;
                    w_cmt.m_slot.tag          = r_tag;
                    w_cmt.m_slot.order        = w_is_alloc ? r_order : 8'd0;
                    w_km = r_fin_hit;
                end
                ara_pkg::REQ_FREE: begin
                    w_cmt.valid  = 1'b1;
                    w_cmt.clr_l  = r_fin.left_hit;
                    w_cmt.clr_r  = r_fin.right_hit;
                    w_cmt.wm     = 1'b1;
                    w_cmt.m_free = 1'b1;
                    w_cmt.m_slot = ara_pkg::mk_free(
                        r_fin.left_hit ? r_fin.left_start : r_fs,
                        r_fin.right_hit ? r_fin.right_end : r_fe);
                    w_km = r_n;
                end
                default: begin
                    w_cmt.valid = 1'b0;
                end
            endcase
        end
    end

    // slot chain
    assign w_v[0]   = r_kick;
    assign w_rec[0] = '0;
    assign w_hit[0] = '0;
    assign w_li[0]  = '0;
    assign w_ri[0]  = '0;
    assign w_e1[0]  = '0;
    assign w_e2[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ara_cell #(
            .IDXW     (IDXW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_req     (w_req),
            .i_cmt     (w_cmt),
            .i_km      (w_km),
            .i_ka      (w_ka),
            .i_kb      (w_kb),
            .i_kl      (r_fin_l),
            .i_kr      (r_fin_r),
            .i_v       (w_v[g]),
            .i_rec     (w_rec[g]),
            .i_hit_idx (w_hit[g]),
            .i_l_idx   (w_li[g]),
            .i_r_idx   (w_ri[g]),
            .i_e1_idx  (w_e1[g]),
            .i_e2_idx  (w_e2[g]),
            .o_v       (w_v[g+1]),
            .o_rec     (w_rec[g+1]),
            .o_hit_idx (w_hit[g+1]),
            .o_l_idx   (w_li[g+1]),
            .o_r_idx   (w_ri[g+1]),
            .o_e1_idx  (w_e1[g+1]),
            .o_e2_idx  (w_e2[g+1]),
            .o_used    (w_used[g])
        );
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs <= '0;
            r_re <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ara_pkg::CFG_REGION_START) begin
                r_rs <= i_cfg_data;
            end else begin
                r_re <= i_cfg_data;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kick  <= 1'b0;
            r_pass2 <= 1'b0;
            r_err   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pass2 <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= S_CHK1;
                    end
                end
                S_CHK1: begin
                    r_err   <= w_chk_err;
                    r_state <= w_chk_err ? S_OUT : S_CHK2;
                end
                S_CHK2: begin
                    if ((w_is_alloc && (r_szovf || w_rsum[64])) ||
                        ((r_op == ara_pkg::REQ_RESERVE) && (r_szovf || w_esum[64]))) begin
                        r_err   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_op == ara_pkg::REQ_INIT) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_state <= S_PREP1;
                    end
                end
                S_PREP1: begin
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    r_kick  <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_v[TABLE_ENTRIES]) begin
                        if ((r_op == ara_pkg::REQ_FREE) && !r_pass2) begin
                            if (w_rec[TABLE_ENTRIES].hit) begin
                                r_pass2 <= 1'b1;
                                r_kick  <= 1'b1;
                            end else begin
                                r_err   <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    if ((r_op == ara_pkg::REQ_ALLOC) || (r_op == ara_pkg::REQ_RESERVE) ||
                        (r_op == ara_pkg::REQ_QUERY)) begin
                        if (!r_fin.hit) begin
                            r_err <= 1'b1;
                        end else if ((r_op != ara_pkg::REQ_QUERY) &&
                                     ((((w_ca > r_fin.slot.start_addr) ||
                                        (w_cb < r_fin.slot.end_addr)) && !r_fin.e1_v) ||
                                      ((w_ca > r_fin.slot.start_addr) &&
                                       (w_cb < r_fin.slot.end_addr) && !r_fin.e2_v))) begin
                            r_err <= 1'b1;
                        end
                    end
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_v || i_ready) begin
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_req_type;
                r_addr  <= i_addr;
                r_size  <= i_req_size;
                r_align <= i_alignment;
                r_gb    <= i_guard_before;
                r_ga    <= i_guard_after;
                r_ph    <= i_place_high;
                r_tag   <= i_alloc_tag;
                r_order <= i_order_hint;
                r_st    <= ara_pkg::ST_OK;
            end
            S_CHK1: begin
                r_st     <= w_chk_st;
                r_amask  <= r_align - 64'd1;
                r_usable <= w_usum[63:0] & ~PMASK;
                r_szovf  <= w_usum[64];
                r_gbytes <= {47'd0, {1'b0, r_gb} + {1'b0, r_ga}} << PLOG;
            end
            S_CHK2: begin
                r_reserved <= w_rsum[63:0];
                r_rend     <= w_esum[63:0];
                if (w_is_alloc && (r_szovf || w_rsum[64])) begin
                    r_st <= ara_pkg::ST_NOSPACE;
                end else if ((r_op == ara_pkg::REQ_RESERVE) && (r_szovf || w_esum[64])) begin
                    r_st <= ara_pkg::ST_INVALID;
                end
            end
            S_SCAN: begin
                if (w_v[TABLE_ENTRIES]) begin
                    r_fin     <= w_rec[TABLE_ENTRIES];
                    r_fin_hit <= w_hit[TABLE_ENTRIES];
                    r_fin_l   <= w_li[TABLE_ENTRIES];
                    r_fin_r   <= w_ri[TABLE_ENTRIES];
                    r_fin_e1  <= w_e1[TABLE_ENTRIES];
                    r_fin_e2  <= w_e2[TABLE_ENTRIES];
                    if ((r_op == ara_pkg::REQ_FREE) && !r_pass2) begin
                        r_n  <= w_hit[TABLE_ENTRIES];
                        r_fs <= w_rec[TABLE_ENTRIES].slot.start_addr;
                        r_fe <= w_rec[TABLE_ENTRIES].slot.end_addr;
                        if (!w_rec[TABLE_ENTRIES].hit) begin
                            r_st <= ara_pkg::ST_NOTFOUND;
                        end
                    end
                end
            end
            S_DEC: begin
                r_pre   <= w_ca > r_fin.slot.start_addr;
                r_suf   <= w_cb < r_fin.slot.end_addr;
                r_ubase <= w_ca + (w_is_alloc ? ({48'd0, r_gb} << PLOG) : 64'd0);
                r_gbq   <= {47'd0, {1'b0, r_fin.slot.guard_before} +
                            {1'b0, r_fin.slot.guard_after}} << PLOG;
                if (!r_fin.hit) begin
                    r_st <= w_is_alloc ? ara_pkg::ST_NOSPACE : ara_pkg::ST_NOTFOUND;
                end else if ((r_op != ara_pkg::REQ_QUERY) &&
                             ((((w_ca > r_fin.slot.start_addr) ||
                                (w_cb < r_fin.slot.end_addr)) && !r_fin.e1_v) ||
                              ((w_ca > r_fin.slot.start_addr) &&
                               (w_cb < r_fin.slot.end_addr) && !r_fin.e2_v))) begin
                    r_st <= ara_pkg::ST_TABLEFULL;
                end
                if ((r_op == ara_pkg::REQ_FREE) || (r_op == ara_pkg::REQ_INIT)) begin
                    r_st <= ara_pkg::ST_OK;
                end
            end
            S_COMMIT: begin
                if (w_is_alloc) begin
                    r_res_base  <= r_ubase;
                    r_res_size  <= r_usable;
                    r_res_rbase <= r_fin.a;
                    r_res_rsize <= r_reserved;
                    r_res_gb    <= r_gb;
                    r_res_ga    <= r_ga;
                    r_res_tag   <= r_tag;
                    r_res_order <= r_order;
                end else begin
                    r_res_base  <= r_fin.slot.usable_base;
                    r_res_size  <= r_fin.len - r_gbq;
                    r_res_rbase <= r_fin.slot.start_addr;
                    r_res_rsize <= r_fin.len;
                    r_res_gb    <= r_fin.slot.guard_before;
                    r_res_ga    <= r_fin.slot.guard_after;
                    r_res_tag   <= r_fin.slot.tag;
                    r_res_order <= r_fin.slot.order;
                end
            end
            default: begin
                r_st <= r_st;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_v || i_ready)) begin
            r_out_st <= r_st;
            if (!r_err && (w_is_alloc || (r_op == ara_pkg::REQ_QUERY))) begin
                r_out_base  <= r_res_base;
                r_out_size  <= r_res_size;
                r_out_rbase <= r_res_rbase;
                r_out_rsize <= r_res_rsize;
                r_out_gb    <= r_res_gb;
                r_out_ga    <= r_res_ga;
                r_out_tag   <= r_res_tag;
                r_out_order <= r_res_order;
            end else begin
                r_out_base  <= '0;
                r_out_size  <= '0;
                r_out_rbase <= '0;
                r_out_rsize <= '0;
                r_out_gb    <= '0;
                r_out_ga    <= '0;
                r_out_tag   <= '0;
                r_out_order <= '0;
            end
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_out_v;
    assign o_status            = r_out_st;
    assign o_res_base          = r_out_base;
    assign o_res_size          = r_out_size;
    assign o_res_reserved_base = r_out_rbase;
    assign o_res_reserved_size = r_out_rsize;
    assign o_res_guard_before  = r_out_gb;
    assign o_res_guard_after   = r_out_ga;
    assign o_res_tag           = r_out_tag;
    assign o_res_order         = r_out_order;

    // checks
    `ARA_ASSERT(a_chain_single, i_clk, i_rst_n, $onehot0(w_v))
    `ARA_NEVER(a_idle_quiet, i_clk, i_rst_n, (r_state == S_IDLE) && (w_v != '0))
    `ARA_ASSERT(a_commit_to_out, i_clk, i_rst_n, (r_state == S_COMMIT) |=> (r_state == S_OUT))
    `ARA_ASSERT(a_init_seeds, i_clk, i_rst_n,
        ((r_state == S_COMMIT) && (r_op == ara_pkg::REQ_INIT) && !r_err) |=>
        (w_used[0] && ($countones(w_used) == 1)))

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the best fit address range allocator: a cycle-free
// model of the range table predicts every result transaction, directed
// requests hit the error paths and the basic paths and random request mixes churn the table
// under several windows with random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import ara_pkg::*;

    localparam int         SLOTS      = 64;
    localparam bit [63:0]  PAGE       = 64'd4096;
    localparam bit [63:0]  PMASK      = 64'hFFF;
    localparam int         MAX_ORDER  = 10;
    localparam logic       CFG_REGION_END = 1'b1;
    localparam int         STALL_LIMIT = 3000;
    localparam int         HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] addr;
        logic [63:0] size;
        logic [63:0] align;
        logic [15:0] gb;
        logic [15:0] ga;
        logic        place_high;
        logic [2:0]  tag;
        logic [7:0]  order;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] base;
        logic [63:0] size;
        logic [63:0] rbase;
        logic [63:0] rsize;
        logic [15:0] gb;
        logic [15:0] ga;
        logic [2:0]  tag;
        logic [7:0]  order;
    } result_t;

    class allocator_scoreboard;
        bit        in_use[SLOTS];
        bit        is_free[SLOTS];
        bit [63:0] r_start[SLOTS];
        bit [63:0] r_end[SLOTS];
        bit [63:0] r_base[SLOTS];
        bit [15:0] r_gb[SLOTS];
        bit [15:0] r_ga[SLOTS];
        bit [2:0]  r_tag[SLOTS];
        bit [7:0]  r_order[SLOTS];
        bit [63:0] win_lo;
        bit [63:0] win_hi;
        result_t   due[$];
        int        errors;

        function void clear_table();
            for (int i = 0; i < SLOTS; i++) begin
                in_use[i] = 0;
                is_free[i] = 0;
            end
        endfunction

        function int first_empty();
            for (int i = 0; i < SLOTS; i++)
                if (!in_use[i]) return i;
            return -1;
        endfunction

        function void make_free(int i, bit [63:0] s, bit [63:0] e);
            in_use[i] = 1;
            is_free[i] = 1;
            r_start[i] = s;
            r_end[i] = e;
            r_base[i] = s;
            r_gb[i] = 0;
            r_ga[i] = 0;
            r_tag[i] = 0;
            r_order[i] = 0;
        endfunction

        function bit [2:0] carve(int c, bit [63:0] a, bit [63:0] b);
            bit [63:0] os, oe;
            int need, n;
            os = r_start[c];
            oe = r_end[c];
            need = int'(a > os) + int'(b < oe);
            n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (!in_use[i]) n++;
            if (n < need) return ST_TABLEFULL;
            if (a > os) make_free(first_empty(), os, a);
            if (b < oe) make_free(first_empty(), b, oe);
            is_free[c] = 0;
            r_start[c] = a;
            r_end[c] = b;
            return ST_OK;
        endfunction

        function result_t report(int i);
            result_t res;
            res = '0;
            res.base = r_base[i];
            res.size = r_end[i] - r_start[i] - (64'(r_gb[i]) + 64'(r_ga[i])) * PAGE;
            res.rbase = r_start[i];
            res.rsize = r_end[i] - r_start[i];
            res.gb = r_gb[i];
            res.ga = r_ga[i];
            res.tag = r_tag[i];
            res.order = r_order[i];
            return res;
        endfunction

        function bit [2:0] do_init();
            if (win_lo >= win_hi) return ST_INVALID;
            if ((win_lo & PMASK) != 0 || (win_hi & PMASK) != 0) return ST_ALIGN;
            clear_table();
            make_free(0, win_lo, win_hi);
            return ST_OK;
        endfunction

        function bit [2:0] do_alloc(req_t r, output result_t res);
            bit [63:0] amask, usable, gbytes, reserved, s, e, a, b, len, add;
            bit [63:0] best_a, best_b;
            int best;
            bit [2:0] st;
            res = '0;
            best = -1;
            best_a = 0;
            best_b = 0;
            if (r.size == 0) return ST_INVALID;
            if (r.align == 0 || (r.align & (r.align - 1)) != 0 || r.align < PAGE)
                return ST_ALIGN;
            if (r.order > MAX_ORDER) return ST_INVALID;
            amask = r.align - 1;
            if (r.size > ~64'd0 - PMASK) return ST_NOSPACE;
            usable = (r.size + PMASK) & ~PMASK;
            gbytes = (64'(r.gb) + 64'(r.ga)) * PAGE;
            if (usable > ~64'd0 - gbytes) return ST_NOSPACE;
            reserved = usable + gbytes;
            for (int i = 0; i < SLOTS; i++) begin
                if (!in_use[i] || !is_free[i]) continue;
                s = r_start[i];
                e = r_end[i];
                len = e - s;
                if (e < s || len < reserved) continue;
                if (r.place_high) begin
                    a = (e - reserved) & ~amask;
                    if (a < s) continue;
                    b = a + reserved;
                end else begin
                    a = s;
                    if ((s & amask) != 0) begin
                        add = r.align - (s & amask);
                        if (s > ~64'd0 - add) continue;
                        a = s + add;
                    end
                    if (a > ~64'd0 - reserved) continue;
                    b = a + reserved;
                    if (b > e) continue;
                end
                if (best < 0 || len < r_end[best] - r_start[best] ||
                    (len == r_end[best] - r_start[best] && s < r_start[best])) begin
                    best = i;
                    best_a = a;
                    best_b = b;
                end
            end
            if (best < 0) return ST_NOSPACE;
            st = carve(best, best_a, best_b);
            if (st != ST_OK) return st;
            r_base[best] = best_a + 64'(r.gb) * PAGE;
            r_gb[best] = r.gb;
            r_ga[best] = r.ga;
            r_tag[best] = r.tag;
            r_order[best] = r.order;
            res = report(best);
            return ST_OK;
        endfunction

        function bit [2:0] do_free(bit [63:0] base);
            int hit;
            bit [63:0] s, e;
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && !is_free[i] && r_base[i] == base) begin
                    hit = i;
                    break;
                end
            if (hit < 0) return ST_NOTFOUND;
            s = r_start[hit];
            e = r_end[hit];
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && is_free[i] && r_end[i] == s && r_start[i] < s) begin
                    s = r_start[i];
                    in_use[i] = 0;
                    is_free[i] = 0;
                    break;
                end
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && is_free[i] && r_start[i] == e && r_end[i] > e) begin
                    e = r_end[i];
                    in_use[i] = 0;
                    is_free[i] = 0;
                    break;
                end
            make_free(hit, s, e);
            return ST_OK;
        endfunction

        function bit [2:0] do_reserve(req_t r);
            bit [63:0] size, e;
            int hit;
            bit [2:0] st;
            hit = -1;
            if (r.size == 0) return ST_INVALID;
            if ((r.addr & PMASK) != 0) return ST_ALIGN;
            if (r.size > ~64'd0 - PMASK) return ST_INVALID;
            size = (r.size + PMASK) & ~PMASK;
            if (r.addr > ~64'd0 - size || r.addr + size == 0) return ST_INVALID;
            e = r.addr + size;
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && is_free[i] && r_start[i] <= r.addr && r_end[i] >= e) begin
                    hit = i;
                    break;
                end
            if (hit < 0) return ST_NOTFOUND;
            st = carve(hit, r.addr, e);
            if (st != ST_OK) return st;
            r_base[hit] = r.addr;
            r_gb[hit] = 0;
            r_ga[hit] = 0;
            r_tag[hit] = r.tag;
            r_order[hit] = 0;
            return ST_OK;
        endfunction

        function bit [2:0] do_query(bit [63:0] a, output result_t res);
            res = '0;
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && !is_free[i] && r_start[i] <= a && a < r_end[i]) begin
                    res = report(i);
                    return ST_OK;
                end
            return ST_NOTFOUND;
        endfunction

        function result_t note_request(req_t r);
            result_t res;
            bit [2:0] st;
            res = '0;
            case (r.kind)
                REQ_INIT:    st = do_init();
                REQ_ALLOC:   st = do_alloc(r, res);
                REQ_FREE:    st = do_free(r.addr);
                REQ_RESERVE: st = do_reserve(r);
                REQ_QUERY:   st = do_query(r.addr, res);
                default:     st = ST_INVALID;
            endcase
            if (st != ST_OK) res = '0;
            res.status = st;
            due.push_back(res);
            return res;
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0) begin
                $display("%0t unexpected result transaction: status %0d", $realtime,
                         got.status);
                errors++;
                return;
            end
            want = due.pop_front();
            compare("status", 64'(want.status), 64'(got.status));
            compare("res_base", want.base, got.base);
            compare("res_size", want.size, got.size);
            compare("res_reserved_base", want.rbase, got.rbase);
            compare("res_reserved_size", want.rsize, got.rsize);
            compare("res_guard_before", 64'(want.gb), 64'(got.gb));
            compare("res_guard_after", 64'(want.ga), 64'(got.ga));
            compare("res_tag", 64'(want.tag), 64'(got.tag));
            compare("res_order", 64'(want.order), 64'(got.order));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_req_type;
    logic [63:0] i_addr;
    logic [63:0] i_req_size;
    logic [63:0] i_alignment;
    logic [15:0] i_guard_before;
    logic [15:0] i_guard_after;
    logic        i_place_high;
    logic [2:0]  i_alloc_tag;
    logic [7:0]  i_order_hint;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [63:0] o_res_base;
    logic [63:0] o_res_size;
    logic [63:0] o_res_reserved_base;
    logic [63:0] o_res_reserved_size;
    logic [15:0] o_res_guard_before;
    logic [15:0] o_res_guard_after;
    logic [2:0]  o_res_tag;
    logic [7:0]  o_res_order;

    address_range_allocator i_dut (.*);

    allocator_scoreboard sb = new();
    bit [63:0] live_bases[$];
    bit        calm;
    bit        hold_req;
    int        init_pct;
    int        max_pages;
    int        idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t req_of(logic [2:0] kind, logic [63:0] addr, logic [63:0] size);
        req_t r;
        r = '0;
        r.kind = kind;
        r.addr = addr;
        r.size = size;
        r.align = PAGE;
        return r;
    endfunction

    function automatic bit [63:0] pick_live();
        return live_bases[$urandom_range(live_bases.size() - 1)];
    endfunction

    function automatic req_t random_request();
        req_t r;
        int p;
        bit [63:0] span;
        span = (sb.win_hi > sb.win_lo) ? sb.win_hi - sb.win_lo : 64'h10000;
        r = req_of(REQ_ALLOC, 0, 0);
        p = $urandom_range(99);
        if (p < 45) begin
            r.size = ($urandom_range(19) == 0) ? rand64()
                   : 64'($urandom_range(1, max_pages * 4096));
            r.align = (p < 2) ? rand64() : (PAGE << $urandom_range(0, 3));
            r.gb = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
            r.ga = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
            r.place_high = 1'($urandom);
            r.tag = 3'($urandom);
            r.order = ($urandom_range(19) == 0) ? 8'($urandom)
                    : 8'($urandom_range(0, MAX_ORDER));
        end else if (p < 70) begin
            r.kind = REQ_FREE;
            r.addr = (live_bases.size() != 0 && $urandom_range(9) != 0) ? pick_live()
                   : rand64();
        end else if (p < 80) begin
            r.kind = REQ_RESERVE;
            r.addr = (sb.win_lo + rand64() % span) & ~PMASK;
            if ($urandom_range(9) == 0) r.addr = rand64();
            r.size = 64'($urandom_range(0, max_pages * 4096));
            r.tag = 3'($urandom);
        end else if (p < 95) begin
            r.kind = REQ_QUERY;
            r.addr = (live_bases.size() != 0 && $urandom_range(3) != 0)
                   ? pick_live() + 64'($urandom_range(0, 8191))
                   : (($urandom_range(1) != 0) ? sb.win_lo + rand64() % span : rand64());
        end else if (p < 95 + init_pct) begin
            r.kind = REQ_INIT;
        end else begin
            r.kind = 3'($urandom_range(5, 7));
        end
        return r;
    endfunction

    task automatic issue(req_t r, output result_t res);
        if (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= r.kind;
        i_addr         <= r.addr;
        i_req_size     <= r.size;
        i_alignment    <= r.align;
        i_guard_before <= r.gb;
        i_guard_after  <= r.ga;
        i_place_high   <= r.place_high;
        i_alloc_tag    <= r.tag;
        i_order_hint   <= r.order;
        do @(posedge i_clk); while (!o_ready);
        res = sb.note_request(r);
        if (res.status == ST_OK) begin
            case (r.kind)
                REQ_ALLOC:   live_bases.push_back(res.base);
                REQ_RESERVE: live_bases.push_back(r.addr);
                REQ_INIT:    live_bases.delete();
                REQ_FREE: begin
                    foreach (live_bases[i])
                        if (live_bases[i] == r.addr) begin
                            live_bases.delete(i);
                            break;
                        end
                end
                default: ;
            endcase
        end
    endtask

    task automatic send(req_t r);
        result_t res;
        issue(r, res);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_window(bit [63:0] lo, bit [63:0] hi);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_REGION_START;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REGION_END;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.win_lo = lo;
        sb.win_hi = hi;
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send(random_request());
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result({o_status, o_res_base, o_res_size, o_res_reserved_base,
                                 o_res_reserved_size, o_res_guard_before,
                                 o_res_guard_after, o_res_tag, o_res_order});
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no transaction for %0d cycles", $realtime,
                         idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        result_t a0, a1, tmp;
        req_t r;
        bit [63:0] lo;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= 1'b0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_req_type     <= '0;
        i_addr         <= '0;
        i_req_size     <= '0;
        i_alignment    <= '0;
        i_guard_before <= '0;
        i_guard_after  <= '0;
        i_place_high   <= 1'b0;
        i_alloc_tag    <= '0;
        i_order_hint   <= '0;
        calm = 0;
        hold_req = 0;
        init_pct = 2;
        max_pages = 6;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: window errors, argument errors, basic paths
        send(req_of(REQ_INIT, 0, 0));
        set_window(64'h10001, 64'h20000);
        send(req_of(REQ_INIT, 0, 0));
        lo = 64'h10_0000;
        set_window(lo, lo + 256 * PAGE);
        send(req_of(REQ_INIT, 0, 0));
        send(req_of(REQ_ALLOC, 0, 0));
        r = req_of(REQ_ALLOC, 0, PAGE);
        r.align = 0;
        send(r);
        r.align = 3 * PAGE;
        send(r);
        r.align = PAGE;
        r.order = 8'(MAX_ORDER + 1);
        send(r);
        send(req_of(REQ_ALLOC, 0, ~64'd0));
        r = req_of(REQ_ALLOC, 0, 64'hFFFF_FFFF_FFFF_0000);
        r.gb = 16'hFFFF;
        r.ga = 16'hFFFF;
        send(r);
        r = req_of(REQ_ALLOC, 0, 1);
        r.gb = 1;
        r.ga = 1;
        r.tag = 3'd7;
        r.order = 8'(MAX_ORDER);
        issue(r, a0);
        r = req_of(REQ_ALLOC, 0, 5000);
        r.align = 4 * PAGE;
        r.place_high = 1'b1;
        r.tag = 3'd3;
        issue(r, a1);
        send(req_of(REQ_QUERY, a0.base, 0));
        send(req_of(REQ_QUERY, a1.base + 100, 0));
        send(req_of(REQ_QUERY, lo + 100 * PAGE, 0));
        send(req_of(REQ_QUERY, 0, 0));
        send(req_of(REQ_RESERVE, lo + 64 * PAGE, 0));
        send(req_of(REQ_RESERVE, lo + PAGE + 1, PAGE));
        send(req_of(REQ_RESERVE, 64'hFFFF_FFFF_FFFF_F000, 1));
        send(req_of(REQ_RESERVE, 0, PAGE));
        r = req_of(REQ_RESERVE, lo + 64 * PAGE, 3 * PAGE);
        r.tag = 3'd5;
        send(r);
        send(req_of(REQ_FREE, 64'h123, 0));
        send(req_of(REQ_FREE, a0.base, 0));
        send(req_of(REQ_FREE, a1.base, 0));
        send(req_of(3'd5, 0, 0));
        send(req_of(3'd6, 0, 0));
        send(req_of(3'd7, ~64'd0, ~64'd0));
        send(req_of(REQ_INIT, 0, 0));

        // small window with one long result hold-off
        random_phase(100);
        hold_req = 1'b1;
        random_phase(500);

        // widest window, first with no idling on either side, then with random stalls
        set_window(64'd0, 64'hFFFF_FFFF_FFFF_F000);
        calm = 1;
        issue(req_of(REQ_INIT, 0, 0), tmp);
        random_phase(250);
        calm = 0;
        random_phase(200);

        // top of address space, single pages, no re-init so the table fills
        set_window(64'hFFFF_FFFF_FFF0_0000, 64'hFFFF_FFFF_FFFF_F000);
        init_pct = 0;
        max_pages = 1;
        send(req_of(REQ_INIT, 0, 0));
        random_phase(600);

        drain();
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: address_range_allocator.f
+incdir+rtl/core
rtl/core/ara_pkg.sv
rtl/core/ara_cell.sv
rtl/core/address_range_allocator.sv
tb/tb_top.sv
